FILE: hw/rtl/u8d_pkg.sv
// ---------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 stream decoder
// Byte classes passed from the front classifier to the back decoder, result
// status codes and the limits used for scalar value checks.
// ---------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    localparam int CP_W      = 21;
    localparam int PAYLOAD_W = 7;

    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_LEAD4 = 3'd3,
        CLS_CONT  = 3'd4,
        CLS_BAD   = 3'd5
    } u8d_class_t;

    typedef enum logic [1:0] {
        ST_POINT   = 2'd0,
        ST_ERROR   = 2'd1,
        ST_DROPPED = 2'd2
    } u8d_status_t;

    // One classified byte as it travels through the queue
    typedef struct packed {
        u8d_class_t           cls;
        logic [PAYLOAD_W-1:0] payload;
        logic                 string_end;
    } u8d_item_t;

    localparam logic [CP_W-1:0] MIN_CP_2B  = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3B  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4B  = 21'h010000;
    localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_FIRST = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_LAST  = 21'h00DFFF;

endpackage

`default_nettype wire

FILE: hw/rtl/u8d_front.sv
// ---------------------------------------------------------------------------
// u8d_front: byte classifier
// Sorts each accepted byte into ASCII, lead, continuation or bad lead and
// strips the marker bits, then writes the result into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module u8d_front (
    input  wire logic             push,
    input  wire logic [7:0]       data_byte,
    input  wire logic             string_end,
    input  wire logic             q_full,
    output u8d_pkg::u8d_item_t    wr_item,
    output logic                  wr_en
);
    import u8d_pkg::*;

    assign wr_en = push && !q_full;

    always_comb
    begin
        wr_item.string_end = string_end;
        wr_item.payload    = data_byte[6:0];
        case (data_byte) inside
            [8'h00:8'h7F]:
            begin
                wr_item.cls = CLS_ASCII;
            end
            [8'h80:8'hBF]:
            begin
                wr_item.cls     = CLS_CONT;
                wr_item.payload = {1'b0, data_byte[5:0]};
            end
            [8'hC2:8'hDF]:
            begin
                wr_item.cls     = CLS_LEAD2;
                wr_item.payload = {2'b00, data_byte[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                wr_item.cls     = CLS_LEAD3;
                wr_item.payload = {3'b000, data_byte[3:0]};
            end
            [8'hF0:8'hF4]:
            begin
                wr_item.cls     = CLS_LEAD4;
                wr_item.payload = {4'b0000, data_byte[2:0]};
            end
            default:
            begin
                // overlong leads C0/C1 and anything above F4
                wr_item.cls     = CLS_BAD;
                wr_item.payload = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/u8d_queue.sv
// ---------------------------------------------------------------------------
// u8d_queue: classified byte queue
// Short first-in first-out buffer between the classifier and the decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module u8d_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire u8d_pkg::u8d_item_t wr_item,
    input  wire logic               rd_en,
    output u8d_pkg::u8d_item_t      rd_item,
    output logic                    q_full,
    output logic                    q_empty
);
    import u8d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8d_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("queue read while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("queue write while full");

endmodule

`default_nettype wire

FILE: hw/rtl/u8d_back.sv
// ---------------------------------------------------------------------------
// u8d_back: sequence decoder
// Gathers continuation bits into the partial code point, checks finished
// values, drops the tail of a failed string and holds one result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module u8d_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire u8d_pkg::u8d_item_t rd_item,
    input  wire logic               q_empty,
    output logic                    rd_en,
    input  wire logic               pop,
    output logic                    empty,
    output logic [20:0]             code_point,
    output logic [1:0]              status,
    output logic                    last
);
    import u8d_pkg::*;

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [1:0]      remaining_reg, remaining_next;
    logic [1:0]      seq_len_reg, seq_len_next;
    logic            discarding_reg, discarding_next;

    logic            out_valid_reg, out_valid_next;
    logic [CP_W-1:0] out_cp_reg, out_cp_next;
    u8d_status_t     out_status_reg, out_status_next;
    logic            out_last_reg, out_last_next;

    logic            res_emit;
    logic            res_fail;
    logic [CP_W-1:0] shifted;
    logic [1:0]      rem_dec;
    logic [CP_W-1:0] min_cp;
    logic            bad_value;

    // take a queued byte whenever the result register is free or draining
    assign rd_en = !q_empty && (!out_valid_reg || pop);

    assign empty      = !out_valid_reg;
    assign code_point = out_cp_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;

    always_comb
    begin
        shifted = {partial_reg[CP_W-7:0], rd_item.payload[5:0]};
        rem_dec = remaining_reg - 2'd1;
        case (seq_len_reg)
            2'd1:    min_cp = MIN_CP_2B;
            2'd2:    min_cp = MIN_CP_3B;
            default: min_cp = MIN_CP_4B;
        endcase
        bad_value = (shifted < min_cp) || (shifted > MAX_CP)
                    || ((shifted >= SURR_FIRST) && (shifted <= SURR_LAST));
    end

    always_comb
    begin
        partial_next    = partial_reg;
        remaining_next  = remaining_reg;
        seq_len_next    = seq_len_reg;
        discarding_next = discarding_reg;
        res_emit        = 1'b0;
        res_fail        = 1'b0;
        out_cp_next     = out_cp_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (rd_en)
        begin
            out_last_next = rd_item.string_end;
            if (discarding_reg)
            begin
                // drop until the string's final byte
                if (rd_item.string_end)
                begin
                    res_emit        = 1'b1;
                    out_cp_next     = '0;
                    out_status_next = ST_DROPPED;
                    out_last_next   = 1'b1;
                    discarding_next = 1'b0;
                    partial_next    = '0;
                    remaining_next  = '0;
                    seq_len_next    = '0;
                end
            end
            else if (remaining_reg == 2'd0)
            begin
                case (rd_item.cls)
                    CLS_ASCII:
                    begin
                        res_emit        = 1'b1;
                        out_cp_next     = CP_W'(rd_item.payload);
                        out_status_next = ST_POINT;
                    end
                    CLS_LEAD2, CLS_LEAD3, CLS_LEAD4:
                    begin
                        partial_next = CP_W'(rd_item.payload);
                        case (rd_item.cls)
                            CLS_LEAD2: remaining_next = 2'd1;
                            CLS_LEAD3: remaining_next = 2'd2;
                            default:   remaining_next = 2'd3;
                        endcase
                        seq_len_next = remaining_next;
                        res_fail     = rd_item.string_end;
                    end
                    default:
                    begin
                        res_fail = 1'b1;
                    end
                endcase
            end
            else if (rd_item.cls != CLS_CONT)
            begin
                res_fail = 1'b1;
            end
            else if (rem_dec != 2'd0)
            begin
                partial_next   = shifted;
                remaining_next = rem_dec;
                res_fail       = rd_item.string_end;
            end
            else if (bad_value)
            begin
                res_fail = 1'b1;
            end
            else
            begin
                res_emit        = 1'b1;
                out_cp_next     = shifted;
                out_status_next = ST_POINT;
                partial_next    = '0;
                remaining_next  = '0;
                seq_len_next    = '0;
            end

            if (res_fail)
            begin
                res_emit        = 1'b1;
                out_cp_next     = '0;
                out_status_next = ST_ERROR;
                partial_next    = '0;
                remaining_next  = '0;
                seq_len_next    = '0;
                discarding_next = !rd_item.string_end;
            end
        end

        if (res_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg    <= '0;
            remaining_reg  <= '0;
            seq_len_reg    <= '0;
            discarding_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            partial_reg    <= partial_next;
            remaining_reg  <= remaining_next;
            seq_len_reg    <= seq_len_next;
            discarding_reg <= discarding_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_emit)
        begin
            out_cp_reg     <= out_cp_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    a_rem_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= seq_len_reg)
        else $error("remaining count exceeds sequence length");

    a_discard_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        discarding_reg |-> (remaining_reg == 2'd0) && (partial_reg == '0))
        else $error("partial sequence kept while discarding");

    a_error_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_POINT) |-> (out_cp_reg == '0))
        else $error("error beat carries a code point");

    a_dropped_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == ST_DROPPED) |-> out_last_reg)
        else $error("discard beat without last");

    a_point_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == ST_POINT) |-> (out_cp_reg <= MAX_CP))
        else $error("code point above range");

endmodule

`default_nettype wire

FILE: hw/rtl/utf8_stream_decoder.sv
// ---------------------------------------------------------------------------
// utf8_stream_decoder: validating UTF-8 byte stream decoder
// Classifier, byte queue and sequence decoder; one result beat per code
// point, per invalid sequence, and per end of a discarded string.
// ---------------------------------------------------------------------------
//  channel   handshake        beat fields
//  input     push / full      data_byte[7:0], string_end
//  result    pop / empty      code_point[20:0], status[1:0], last
//
//  One byte per cycle in sustained flow while results are popped; a byte that
//  yields a result reaches the result ports through the queue memory and then
//  the result register. Throughput is set by the decoder taking one queued byte
//  per cycle while the result register is free or popped. The byte queue holds
//  QUEUE_DEPTH beats; full rises only when the result side stalls long enough
//  to fill it. Reset clears the queue, the partial sequence and the valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        string_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [20:0]      code_point,
    output logic [1:0]       status,
    output logic             last
);
    import u8d_pkg::*;

    u8d_item_t wr_item;
    u8d_item_t rd_item;
    logic      wr_en;
    logic      rd_en;
    logic      q_full;
    logic      q_empty;

    assign full = q_full;

    u8d_front u_front (
        .push       (push),
        .data_byte  (data_byte),
        .string_end (string_end),
        .q_full     (q_full),
        .wr_item    (wr_item),
        .wr_en      (wr_en)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_item (wr_item),
        .rd_en   (rd_en),
        .rd_item (rd_item),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_item    (rd_item),
        .q_empty    (q_empty),
        .rd_en      (rd_en),
        .pop        (pop),
        .empty      (empty),
        .code_point (code_point),
        .status     (status),
        .last       (last)
    );

endmodule

`default_nettype wire
